[design/ed_pkg.sv]
// Shared constants and types for the edit distance block.
// Depends on nothing; ed_cell and edit_distance refer to it by scoped names.
package ed_pkg;

  localparam int MAX_LEN  = 256;
  localparam int LEN_W    = $clog2(MAX_LEN + 1);
  localparam int IDX_W    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int ROW_AW   = LEN_W;
  localparam int COST_W   = LEN_W;
  localparam int DIST_W   = 9;
  localparam int DIST_MAX = 511;
  localparam int SAT_W    = (COST_W > DIST_W) ? COST_W : DIST_W;
  localparam int FUNC_W   = 2;
  localparam int SYM_W    = 8;

  localparam logic [FUNC_W-1:0] FN_LOAD_A = 2'd0;
  localparam logic [FUNC_W-1:0] FN_LOAD_B = 2'd1;
  localparam logic [FUNC_W-1:0] FN_CMP    = 2'd2;

  typedef struct packed {
    logic [COST_W-1:0] diag;
    logic [COST_W-1:0] above;
    logic [COST_W-1:0] left;
    logic              mismatch;
  } cell_in_t;

endpackage

[design/ed_ram.sv]
// Generic single-write, single-read memory with registered read data.
// Depends on nothing; used for both strings and the working cost row.
module ed_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[design/ed_cell.sv]
// Shared cell unit: minimum of substitution, deletion and insertion costs.
// Depends on ed_pkg for the cost width and the cell operand struct.
module ed_cell (
  input  ed_pkg::cell_in_t           op,
  output logic [ed_pkg::COST_W-1:0]  best
);

  logic [ed_pkg::COST_W:0] sub_c;
  logic [ed_pkg::COST_W:0] del_c;
  logic [ed_pkg::COST_W:0] ins_c;
  logic [ed_pkg::COST_W:0] min_sd;
  logic [ed_pkg::COST_W:0] min_all;

  always_comb begin
    sub_c   = {1'b0, op.diag} + {{ed_pkg::COST_W{1'b0}}, op.mismatch};
    del_c   = {1'b0, op.above} + (ed_pkg::COST_W + 1)'(1);
    ins_c   = {1'b0, op.left} + (ed_pkg::COST_W + 1)'(1);
    min_sd  = (sub_c < del_c) ? sub_c : del_c;
    min_all = (ins_c < min_sd) ? ins_c : min_sd;
    best    = min_all[ed_pkg::COST_W-1:0];
  end

endmodule

[design/edit_distance.sv]
// Levenshtein edit distance unit: top level with load path, sweep sequencer and result register.
// Depends on ed_pkg, ed_ram and ed_cell.
//
// Load transactions (func 0 / func 1) are taken one per cycle while in_stall is low and append
// a byte to the first or second string; bytes past MAX_LEN are dropped. A compute transaction
// (func 2) clears both strings and starts a single-row dynamic programming sweep through one
// shared cell unit, one matrix cell per cycle, limited by the single write port of the cost-row
// memory. While the sweep runs in_stall is high; the distance then sits in an output register
// until taken, while new loads are accepted.
module edit_distance (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [ed_pkg::FUNC_W-1:0]   in_func,
  input  logic [ed_pkg::SYM_W-1:0]    in_symbol,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ed_pkg::DIST_W-1:0]   out_distance
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_INIT = 3'd1;
  localparam logic [2:0] ST_ROW  = 3'd2;
  localparam logic [2:0] ST_CELL = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  localparam int LW = ed_pkg::LEN_W;
  localparam int IW = ed_pkg::IDX_W;
  localparam int CW = ed_pkg::COST_W;

  logic [2:0]    state_r, state_nxt;
  logic [LW-1:0] len_a_r, len_a_nxt;
  logic [LW-1:0] len_b_r, len_b_nxt;
  logic [LW-1:0] na_r, na_nxt;
  logic [LW-1:0] nb_r, nb_nxt;
  logic [LW-1:0] i_r, i_nxt;
  logic [LW-1:0] j_r, j_nxt;
  logic [CW-1:0] diag_r, diag_nxt;
  logic [CW-1:0] left_r, left_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [ed_pkg::DIST_W-1:0] out_dist_r, out_dist_nxt;

  logic          in_acc;
  logic          out_free;

  logic          a_we, a_re;
  logic [IW-1:0] a_waddr, a_raddr;
  logic [ed_pkg::SYM_W-1:0] a_rdata;
  logic          b_we, b_re;
  logic [IW-1:0] b_waddr, b_raddr;
  logic [ed_pkg::SYM_W-1:0] b_rdata;
  logic          row_we, row_re;
  logic [ed_pkg::ROW_AW-1:0] row_waddr, row_raddr;
  logic [CW-1:0] row_wdata, row_rdata;

  ed_pkg::cell_in_t cell_op;
  logic [CW-1:0]    cell_best;
  logic [ed_pkg::SAT_W-1:0] fin_ext;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  ed_ram #(.DEPTH(ed_pkg::MAX_LEN), .WIDTH(ed_pkg::SYM_W)) u_str_a (
    .clk(clk), .wr_en(a_we), .wr_addr(a_waddr), .wr_data(in_symbol),
    .rd_en(a_re), .rd_addr(a_raddr), .rd_data(a_rdata)
  );

  ed_ram #(.DEPTH(ed_pkg::MAX_LEN), .WIDTH(ed_pkg::SYM_W)) u_str_b (
    .clk(clk), .wr_en(b_we), .wr_addr(b_waddr), .wr_data(in_symbol),
    .rd_en(b_re), .rd_addr(b_raddr), .rd_data(b_rdata)
  );

  ed_ram #(.DEPTH(ed_pkg::MAX_LEN + 1), .WIDTH(CW)) u_row (
    .clk(clk), .wr_en(row_we), .wr_addr(row_waddr), .wr_data(row_wdata),
    .rd_en(row_re), .rd_addr(row_raddr), .rd_data(row_rdata)
  );

  ed_cell u_cell (
    .op(cell_op),
    .best(cell_best)
  );

  always_comb begin
    a_we    = in_acc && (in_func == ed_pkg::FN_LOAD_A) && (len_a_r < LW'(ed_pkg::MAX_LEN));
    a_waddr = len_a_r[IW-1:0];
    a_re    = (state_r == ST_ROW);
    a_raddr = IW'(i_r - LW'(1));

    b_we    = in_acc && (in_func == ed_pkg::FN_LOAD_B) && (len_b_r < LW'(ed_pkg::MAX_LEN));
    b_waddr = len_b_r[IW-1:0];
    b_re    = (state_r == ST_ROW) || ((state_r == ST_CELL) && (j_r != nb_r));
    b_raddr = (state_r == ST_ROW) ? '0 : j_r[IW-1:0];

    cell_op.diag     = diag_r;
    cell_op.above    = row_rdata;
    cell_op.left     = left_r;
    cell_op.mismatch = (a_rdata != b_rdata);

    row_we    = 1'b0;
    row_waddr = j_r;
    row_wdata = CW'(j_r);
    row_re    = 1'b0;
    row_raddr = ed_pkg::ROW_AW'(j_r + LW'(1));
    unique case (state_r)
      ST_INIT: begin
        row_we = 1'b1;
      end
      ST_ROW: begin
        row_we    = 1'b1;
        row_waddr = '0;
        row_wdata = CW'(i_r);
        row_re    = (nb_r != '0);
        row_raddr = ed_pkg::ROW_AW'(1);
      end
      ST_CELL: begin
        row_we    = 1'b1;
        row_wdata = cell_best;
        row_re    = (j_r != nb_r);
      end
      ST_FIN: begin
        row_re    = 1'b1;
        row_raddr = nb_r;
      end
      default: begin
      end
    endcase

    fin_ext = ed_pkg::SAT_W'(row_rdata);
  end

  always_comb begin
    state_nxt     = state_r;
    len_a_nxt     = len_a_r;
    len_b_nxt     = len_b_r;
    na_nxt        = na_r;
    nb_nxt        = nb_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    diag_nxt      = diag_r;
    left_nxt      = left_r;
    out_dist_nxt  = out_dist_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (a_we) begin
      len_a_nxt = len_a_r + LW'(1);
    end
    if (b_we) begin
      len_b_nxt = len_b_r + LW'(1);
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_func == ed_pkg::FN_CMP)) begin
          na_nxt    = len_a_r;
          nb_nxt    = len_b_r;
          len_a_nxt = '0;
          len_b_nxt = '0;
          j_nxt     = '0;
          state_nxt = ST_INIT;
        end
      end
      ST_INIT: begin
        if (j_r == nb_r) begin
          i_nxt     = LW'(1);
          state_nxt = (na_r == '0) ? ST_FIN : ST_ROW;
        end else begin
          j_nxt = j_r + LW'(1);
        end
      end
      ST_ROW: begin
        diag_nxt = CW'(i_r - LW'(1));
        left_nxt = CW'(i_r);
        j_nxt    = LW'(1);
        if (nb_r != '0) begin
          state_nxt = ST_CELL;
        end else if (i_r == na_r) begin
          state_nxt = ST_FIN;
        end else begin
          i_nxt = i_r + LW'(1);
        end
      end
      ST_CELL: begin
        left_nxt = cell_best;
        diag_nxt = row_rdata;
        if (j_r == nb_r) begin
          if (i_r == na_r) begin
            state_nxt = ST_FIN;
          end else begin
            i_nxt     = i_r + LW'(1);
            state_nxt = ST_ROW;
          end
        end else begin
          j_nxt = j_r + LW'(1);
        end
      end
      ST_FIN: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_dist_nxt  = (fin_ext > ed_pkg::SAT_W'(ed_pkg::DIST_MAX))
                          ? ed_pkg::DIST_W'(ed_pkg::DIST_MAX)
                          : ed_pkg::DIST_W'(fin_ext);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_a_r     <= '0;
      len_b_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_a_r     <= len_a_nxt;
      len_b_r     <= len_b_nxt;
      out_valid_r <= out_valid_nxt;
    end
    na_r       <= na_nxt;
    nb_r       <= nb_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    diag_r     <= diag_nxt;
    left_r     <= left_nxt;
    out_dist_r <= out_dist_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_distance = out_dist_r;

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (len_a_r <= LW'(ed_pkg::MAX_LEN)) && (len_b_r <= LW'(ed_pkg::MAX_LEN)))
    else $error("string length beyond MAX_LEN");

  a_cmp_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_func == ed_pkg::FN_CMP)) |=> (len_a_r == '0) && (len_b_r == '0))
    else $error("compute transaction did not clear the strings");

  a_cell_col: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CELL) |-> (j_r != '0) && (j_r <= nb_r))
    else $error("column index out of range in sweep");

  a_row_idx: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_ROW) || (state_r == ST_CELL)) |-> (i_r != '0) && (i_r <= na_r))
    else $error("row index out of range in sweep");

  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DONE) && out_free) |=> out_valid_r && (state_r == ST_IDLE))
    else $error("finished sweep did not load the result register");

endmodule
